@@ rtl/bmtrk_pkg.sv @@
// Shared types and constants for the bitmap first-clear tracker.
package bmtrk_pkg;

   localparam int unsigned MAX_BITS   = 1024;
   localparam int unsigned WORD_BITS  = 32;
   localparam int unsigned NUM_WORDS  = MAX_BITS / WORD_BITS;
   localparam int unsigned WADDR_W    = $clog2(NUM_WORDS);
   localparam int unsigned BOFS_W     = $clog2(WORD_BITS);
   localparam int unsigned INDEX_W    = WADDR_W + BOFS_W;
   localparam int unsigned COUNT_W    = INDEX_W + 1;
   localparam int unsigned DATA_W     = 32;
   localparam int unsigned ADDR_W     = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_BITS);
   localparam logic [ADDR_W-1:0]  REG_BIT_COUNT = '0;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_SET   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FIND,
      ST_SCAN
   } state_type;

endpackage

@@ rtl/bitmap_tracker_first_unset.sv @@
// Bitmap tracker: word read, bit set, clear all, with lowest-clear-bit search.
// An accepted request passes the EXEC, FIND and SCAN states and the output registers; a new
// request is taken only once its result is loaded. The sequencer does access, modify/writeback,
// summary read and bit scan on the single word memory, one step per cycle while not stalled.
// Reset (synchronous): map reads all zero, set count 0, bit_count = 1024; no clearing pass.
module bitmap_tracker_first_unset (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [9:0]  req_bit_index,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_word_value,
   output logic [10:0] rsp_first_clear,
   output logic        rsp_all_set,
   output logic [10:0] rsp_set_total,
   output logic        rsp_index_error,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int unsigned NW = bmtrk_pkg::NUM_WORDS;
   localparam int unsigned WB = bmtrk_pkg::WORD_BITS;
   localparam int unsigned AW = bmtrk_pkg::WADDR_W;
   localparam int unsigned BW = bmtrk_pkg::BOFS_W;
   localparam int unsigned IW = bmtrk_pkg::INDEX_W;
   localparam int unsigned CW = bmtrk_pkg::COUNT_W;

   // ------------------------------------------------------------------
   // Configuration register
   // ------------------------------------------------------------------
   logic [CW-1:0] bit_count_ff, bit_count_in;
   logic          cfg_wr;
   logic [CW-1:0] cfg_val;

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite && (paddr[2] == bmtrk_pkg::REG_BIT_COUNT[2]);
   assign cfg_val = pwdata[CW-1:0];

   always_comb begin
      bit_count_in = bit_count_ff;
      if (cfg_wr) begin
         // oversized counts saturate at the map size
         bit_count_in = (cfg_val > bmtrk_pkg::COUNT_MAX) ? bmtrk_pkg::COUNT_MAX : cfg_val;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == bmtrk_pkg::REG_BIT_COUNT[2]) begin
         prdata = 32'(bit_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff <= bmtrk_pkg::COUNT_MAX;
      end else begin
         bit_count_ff <= bit_count_in;
      end
   end

   // ------------------------------------------------------------------
   // State, sequencer and control signals
   // ------------------------------------------------------------------
   bmtrk_pkg::state_type state_ff, state_in;

   // per-word flags: valid = written since last clear, full = all ones
   logic [NW-1:0] valid_ff, valid_in;
   logic [NW-1:0] full_ff, full_in;
   logic [CW-1:0] count_ff, count_in;

   // latched request
   bmtrk_pkg::op_type op_ff;
   logic [IW-1:0]     idx_ff;

   // results of the execute step
   logic [31:0] word_ff, word_in;
   logic        err_ff, err_in;

   // search registers
   logic [AW-1:0] find_word_ff;
   logic          find_none_ff;

   // memory and read side
   logic [WB-1:0] mem [NW];
   logic [WB-1:0] rd_a_ff, rd_b_ff;
   logic          vld_a_ff, vld_b_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr_a, rd_addr_b;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [WB-1:0] wr_data;

   logic          accept;
   logic          out_load;

   // output registers
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_word_ff;
   logic [CW-1:0] rsp_first_ff;
   logic          rsp_all_ff;
   logic [CW-1:0] rsp_total_ff;
   logic          rsp_err_ff;

   assign accept = req_valid && !req_stall;

   // priority encode of the first word that is not full
   logic [AW-1:0] pe_word;
   logic          pe_none;
   always_comb begin
      pe_word = '0;
      pe_none = 1'b1;
      for (int i = NW - 1; i >= 0; i--) begin
         if (!full_ff[i]) begin
            pe_word = AW'(i);
            pe_none = 1'b0;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bmtrk_pkg::ST_IDLE: if (accept) state_in = bmtrk_pkg::ST_EXEC;
         bmtrk_pkg::ST_EXEC: state_in = bmtrk_pkg::ST_FIND;
         bmtrk_pkg::ST_FIND: state_in = bmtrk_pkg::ST_SCAN;
         bmtrk_pkg::ST_SCAN: if (out_load) state_in = bmtrk_pkg::ST_IDLE;
         default:            state_in = bmtrk_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      rd_addr_a = req_bit_index[IW-1:BW];
      rd_addr_b = AW'(req_bit_index[IW-1:BW] + 1'b1);
      out_load  = 1'b0;
      case (state_ff)
         bmtrk_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            rd_en     = accept;
         end
         bmtrk_pkg::ST_EXEC: begin
            req_stall = 1'b1;
         end
         bmtrk_pkg::ST_FIND: begin
            // summary vector already reflects this request's update
            rd_en     = 1'b1;
            rd_addr_a = pe_word;
            rd_addr_b = pe_word;
         end
         bmtrk_pkg::ST_SCAN: begin
            out_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Execute step: read extract, bit set, clear all
   // ------------------------------------------------------------------
   logic [WB-1:0]   cur_a, cur_b;
   logic [2*WB-1:0] pair_sh;
   logic [CW-1:0]   avail;
   logic [31:0]     avail_mask;
   logic [WB-1:0]   set_mask, set_word;
   logic            in_range;

   assign cur_a = vld_a_ff ? rd_a_ff : '0;
   assign cur_b = vld_b_ff ? rd_b_ff : '0;

   always_comb begin
      in_range   = {1'b0, idx_ff} < bit_count_ff;
      pair_sh    = {cur_b, cur_a} >> idx_ff[BW-1:0];
      avail      = bit_count_ff - {1'b0, idx_ff};
      avail_mask = (avail >= CW'(32)) ? 32'hffffffff
                                      : ((32'h1 << avail[4:0]) - 32'h1);
      set_mask   = WB'(1) << idx_ff[BW-1:0];
      set_word   = cur_a | set_mask;

      word_in  = word_ff;
      err_in   = err_ff;
      valid_in = valid_ff;
      full_in  = full_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff[IW-1:BW];
      wr_data  = set_word;

      if (state_ff == bmtrk_pkg::ST_EXEC) begin
         word_in = '0;
         err_in  = 1'b0;
         case (op_ff)
            bmtrk_pkg::OP_READ: begin
               if (in_range) word_in = pair_sh[31:0] & avail_mask;
               else          err_in  = 1'b1;
            end
            bmtrk_pkg::OP_SET: begin
               if (in_range) begin
                  wr_en = 1'b1;
                  valid_in[idx_ff[IW-1:BW]] = 1'b1;
                  full_in[idx_ff[IW-1:BW]]  = &set_word;
                  if ((cur_a & set_mask) == '0) count_in = count_ff + 1'b1;
               end else begin
                  err_in = 1'b1;
               end
            end
            bmtrk_pkg::OP_CLEAR: begin
               valid_in = '0;
               full_in  = '0;
               count_in = '0;
            end
            default: begin
               word_in = '0;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Scan step: lowest zero in the first non-full word
   // ------------------------------------------------------------------
   logic [WB-1:0] scan_word;
   logic [BW-1:0] zero_bit;
   logic [CW-1:0] cand, first_clear;

   assign scan_word = vld_a_ff ? rd_a_ff : '0;

   always_comb begin
      zero_bit = '0;
      for (int i = WB - 1; i >= 0; i--) begin
         if (!scan_word[i]) zero_bit = BW'(i);
      end
      cand        = find_none_ff ? bmtrk_pkg::COUNT_MAX : {1'b0, find_word_ff, zero_bit};
      // padding and bits past the count never count as clear
      first_clear = (cand < bit_count_ff) ? cand : bit_count_ff;
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmtrk_pkg::ST_IDLE;
         valid_ff     <= '0;
         full_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         full_ff      <= full_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= bmtrk_pkg::op_type'(req_type);
         idx_ff <= req_bit_index;
      end
      word_ff <= word_in;
      err_ff  <= err_in;
      if (state_ff == bmtrk_pkg::ST_FIND) begin
         find_word_ff <= pe_word;
         find_none_ff <= pe_none;
      end
      if (out_load) begin
         rsp_word_ff  <= word_ff;
         rsp_first_ff <= first_clear;
         rsp_all_ff   <= (count_ff == bit_count_ff);
         rsp_total_ff <= count_ff;
         rsp_err_ff   <= err_ff;
      end
   end

   // word memory: one write, two reads, registered read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   // valid flags sampled alongside the read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         vld_a_ff <= valid_ff[rd_addr_a];
         vld_b_ff <= valid_ff[rd_addr_b];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_word_value  = rsp_word_ff;
   assign rsp_first_clear = rsp_first_ff;
   assign rsp_all_set     = rsp_all_ff;
   assign rsp_set_total   = rsp_total_ff;
   assign rsp_index_error = rsp_err_ff;

endmodule

@@ tb/tb_bmtrk_sb.sv @@
`timescale 1ns / 100ps
// Scoreboard package: predictor of the bitmap tracker and in-order result checker.
package tb_bmtrk_sb_pkg;
   import bmtrk_pkg::*;

   typedef struct packed {
      logic [31:0]        word_value;
      logic [COUNT_W-1:0] first_clear;
      logic               all_set;
      logic [COUNT_W-1:0] set_total;
      logic               index_error;
   } status_word_t;

   class bmtrk_scoreboard;
      logic [MAX_BITS-1:0] flag_map;
      logic [COUNT_W-1:0]  bits_in_use;
      logic [COUNT_W-1:0]  bits_set;
      status_word_t        status_q[$];
      int                  errors;

      function new();
         flag_map    = '0;
         bits_set    = '0;
         bits_in_use = COUNT_MAX;
         errors      = 0;
      endfunction

      // Only the low COUNT_W bits are kept; oversize values clamp to MAX_BITS.
      function void write_bit_count(logic [31:0] data);
         logic [COUNT_W-1:0] v;
         v = data[COUNT_W-1:0];
         bits_in_use = (v > COUNT_MAX) ? COUNT_MAX : v;
      endfunction

      function int pending();
         return status_q.size();
      endfunction

      function void note_request(op_type op, logic [INDEX_W-1:0] idx);
         status_word_t want;
         int unsigned  pos;
         want = '0;
         case (op)
            OP_READ: begin
               if (idx >= bits_in_use) begin
                  want.index_error = 1'b1;
               end else begin
                  for (int i = 0; i < 32; i++) begin
                     pos = idx + i;
                     if (pos < bits_in_use && flag_map[pos])
                        want.word_value[i] = 1'b1;
                  end
               end
            end
            OP_SET: begin
               if (idx >= bits_in_use) begin
                  want.index_error = 1'b1;
               end else if (!flag_map[idx]) begin
                  flag_map[idx] = 1'b1;
                  bits_set++;
               end
            end
            OP_CLEAR: begin
               flag_map = '0;
               bits_set = '0;
            end
            default: ;
         endcase
         // status after the request; bits past the count never look clear
         want.first_clear = bits_in_use;
         for (int i = 0; i < bits_in_use; i++) begin
            if (!flag_map[i]) begin
               want.first_clear = COUNT_W'(i);
               break;
            end
         end
         want.all_set   = (bits_set == bits_in_use);
         want.set_total = bits_set;
         status_q.push_back(want);
      endfunction

      function void check_result(status_word_t got);
         status_word_t want;
         if (status_q.size() == 0) begin
            $error("result word with no request outstanding");
            errors++;
            return;
         end
         want = status_q.pop_front();
         if (got.word_value !== want.word_value) begin
            $error("word_value: expected %0h, got %0h", want.word_value, got.word_value);
            errors++;
         end
         if (got.first_clear !== want.first_clear) begin
            $error("first_clear: expected %0d, got %0d", want.first_clear, got.first_clear);
            errors++;
         end
         if (got.all_set !== want.all_set) begin
            $error("all_set: expected %0b, got %0b", want.all_set, got.all_set);
            errors++;
         end
         if (got.set_total !== want.set_total) begin
            $error("set_total: expected %0d, got %0d", want.set_total, got.set_total);
            errors++;
         end
         if (got.index_error !== want.index_error) begin
            $error("index_error: expected %0b, got %0b", want.index_error, got.index_error);
            errors++;
         end
      endfunction
   endclass

endpackage

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Top-level testbench for the bitmap tracker: stimulus, CSR access and result checking.
module tb_top;
   import bmtrk_pkg::*;
   import tb_bmtrk_sb_pkg::*;

   localparam int          CYCLE_LIMIT = 500000;
   localparam int          LONG_HOLD   = 300;    // receiver back-pressure burst, in cycles
   localparam int          DRAIN_PAUSE = 8;      // a margin over the request-to-result latency
   localparam logic [2:0]  ADDR_SPARE  = 3'd4;   // no register decoded here

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type      = OP_READ;
   logic [9:0]  req_bit_index = '0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [31:0] rsp_word_value;
   logic [10:0] rsp_first_clear;
   logic        rsp_all_set;
   logic [10:0] rsp_set_total;
   logic        rsp_index_error;
   logic        psel          = 1'b0;
   logic        penable       = 1'b0;
   logic        pwrite        = 1'b0;
   logic [2:0]  paddr         = '0;
   logic [31:0] pwdata        = '0;
   logic [31:0] prdata;
   logic        pready;

   bmtrk_scoreboard sb = new();

   // Idling control shared by both sides
   bit calm         = 1'b0;   // no random gaps on either side while set
   bit rcv_hold_req = 1'b0;   // one-shot request for a long receiver hold-off
   int rcv_hold_left = 0;
   int rcv_wait      = 0;
   int cycle_count   = 0;
   status_word_t got_word;

   bitmap_tracker_first_unset u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_bit_index   (req_bit_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_word_value  (rsp_word_value),
      .rsp_first_clear (rsp_first_clear),
      .rsp_all_set     (rsp_all_set),
      .rsp_set_total   (rsp_set_total),
      .rsp_index_error (rsp_index_error),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #6 clock = ~clock;

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result side. Outputs are sampled at the edge, before this edge's updates land,
   // so a word counts as taken exactly when valid was high and stall low.
   // After each taken word a fresh random wait is drawn unless calm is set; a long hold-off
   // requested by the stimulus overrides it and lets the block back up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_word.word_value  = rsp_word_value;
            got_word.first_clear = rsp_first_clear;
            got_word.all_set     = rsp_all_set;
            got_word.set_total   = rsp_set_total;
            got_word.index_error = rsp_index_error;
            sb.check_result(got_word);
            rcv_wait = calm ? 0 : $urandom_range(0, 10);
         end
         if (rcv_hold_req) begin
            rcv_hold_req  = 1'b0;
            rcv_hold_left = LONG_HOLD;
         end
         if (rcv_hold_left > 0) begin
            rcv_hold_left--;
            rsp_stall <= 1'b1;
         end else if (rcv_wait > 0) begin
            rcv_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one request word and hold it until taken. Valid is left high on return,
   // so a back-to-back word never drops valid within one time step.
   task automatic send_request(op_type op, logic [9:0] idx);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= op;
      req_bit_index <= idx;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, idx);
   endtask

   task automatic req_idle();
      req_valid <= 1'b0;
   endtask

   // Sender pause: nothing outstanding, then a DRAIN_PAUSE wait for the pipeline to settle.
   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   // APB write: setup phase, then access until pready, then back to idle.
   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // APB read of bit_count, compared with the predictor's copy.
   task automatic check_csr();
      logic [31:0] want;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= REG_BIT_COUNT;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      want = 32'(sb.bits_in_use);
      if (prdata !== want) begin
         $error("bit_count readback: expected %0d, got %0d", want, prdata);
         sb.errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Reconfigure the map size while idle; upper data bits are random noise.
   task automatic set_bit_count(logic [10:0] count);
      logic [31:0] data;
      data = {$urandom()} & 32'hFFFF_F800;
      data[10:0] = count;
      req_idle();
      wait_drained();
      csr_write(REG_BIT_COUNT, data);
      sb.write_bit_count(data);
      check_csr();
   endtask

   // Index mix: mostly in range, some around the count boundary, some anywhere.
   function automatic logic [9:0] pick_index(logic [10:0] bc);
      int r;
      int lo;
      int hi;
      r = $urandom_range(0, 99);
      if (bc == 0 || r < 15)
         return 10'($urandom_range(0, 1023));
      if (r < 30) begin
         lo = (bc > 3) ? bc - 3 : 0;
         hi = (bc + 3 > 1023) ? 1023 : bc + 3;
         return 10'($urandom_range(hi, lo));
      end
      hi = (bc > 1024) ? 1023 : bc - 1;
      return 10'($urandom_range(hi, 0));
   endfunction

   // Mostly sets and reads so small maps fill up; clears and unused codes now and then.
   task automatic random_request();
      int r;
      op_type op;
      r = $urandom_range(0, 99);
      if (r < 55)      op = OP_SET;
      else if (r < 90) op = OP_READ;
      else if (r < 94) op = OP_CLEAR;
      else             op = OP_NONE;
      send_request(op, pick_index(sb.bits_in_use));
   endtask

   initial begin
      logic [10:0] counts[22];
      int n;

      counts = '{11'd1024, 11'd0, 11'd1, 11'd2, 11'd5, 11'd31, 11'd32, 11'd33,
                 11'd64, 11'd2047, 11'd1023, 11'd100, 11'd17, 11'd1500, 11'd1024,
                 11'd40, 11'd0, 11'd3, 11'd0, 11'd0, 11'd9, 11'd0};
      // three settings drawn at random, one of them over the whole register range
      counts[18] = 11'($urandom_range(0, 2047));
      counts[19] = 11'($urandom_range(0, 1024));
      counts[21] = 11'($urandom_range(0, 64));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset value, then a write to an undecoded address must leave it alone.
      check_csr();
      csr_write(ADDR_SPARE, 32'hFFFF_FFFF);
      check_csr();

      // Directed: empty map, word boundaries, top bit, repeat set, unused code, clear.
      calm = 1'b1;
      send_request(OP_READ,  10'd0);
      send_request(OP_NONE,  10'd1023);
      send_request(OP_SET,   10'd0);
      send_request(OP_SET,   10'd0);      // already set: count unchanged
      send_request(OP_SET,   10'd31);
      send_request(OP_SET,   10'd32);
      send_request(OP_SET,   10'd1023);
      send_request(OP_READ,  10'd0);
      send_request(OP_READ,  10'd1);      // word straddling two map words
      send_request(OP_READ,  10'd992);
      send_request(OP_READ,  10'd1000);   // runs off the end of the map
      send_request(OP_READ,  10'd1023);
      send_request(OP_CLEAR, 10'd512);
      send_request(OP_READ,  10'd0);

      // Tiny map: fill it, then poke past the end; padding bits never count as clear.
      set_bit_count(11'd3);
      send_request(OP_SET,   10'd0);
      send_request(OP_SET,   10'd1);
      send_request(OP_SET,   10'd2);      // map full
      send_request(OP_SET,   10'd3);      // out of range
      send_request(OP_READ,  10'd3);      // out of range
      send_request(OP_READ,  10'd0);

      // Empty map: every read and set is out of range.
      set_bit_count(11'd0);
      send_request(OP_READ,  10'd0);
      send_request(OP_SET,   10'd0);
      send_request(OP_CLEAR, 10'd0);
      send_request(OP_NONE,  10'd0);

      // Random phases. State carries over, so shrinking the count leaves
      // stray set bits counted beyond the end.
      for (int p = 0; p < 22; p++) begin
         set_bit_count(counts[p]);
         calm = ($urandom_range(0, 3) == 0);
         if (p == 7) begin
            // Long receiver hold-off while the sender keeps offering words.
            calm = 1'b1;
            rcv_hold_req = 1'b1;
         end
         n = 60;
         for (int k = 0; k < n; k++) begin
            random_request();
            if (k == 30 && p % 5 == 2) begin
               // sender pause until every outstanding result is back
               req_idle();
               wait_drained();
            end
         end
      end

      req_idle();
      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.pending() == 0 && sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
